// ===== sv/cpa_pkg.sv =====
// Package for the CIDR prefix aggregator: item and entry types, kind and
// status codes, and the prefix mask function. No dependencies.
package cpa_pkg;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [2:0] ST_PUSHED    = 3'd0;
  localparam logic [2:0] ST_MERGED    = 3'd1;
  localparam logic [2:0] ST_COVERED   = 3'd2;
  localparam logic [2:0] ST_UNALIGNED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_OK        = 3'd5;
  localparam logic [2:0] ST_RANGE     = 3'd6;

  localparam logic [5:0] MAX_PREFIX = 6'd32;
  localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] network;
    logic [5:0]  prefix;
    logic [9:0]  index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] count;
    logic [31:0] entry_network;
    logic [5:0]  entry_prefix;
  } out_item_t;

  typedef struct packed {
    logic [31:0] net;
    logic [5:0]  len;
  } entry_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_CMP
  } fsm_t;

  // Network mask of a prefix length; lengths of 32 and above give all ones.
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len >= MAX_PREFIX) begin
      m = ALL_ONES;
    end else begin
      m = ~(ALL_ONES >> len);
    end
    return m;
  endfunction

endpackage

// ===== sv/cpa_stack_mem.sv =====
// Stack storage of the CIDR prefix aggregator: one write port and one read
// port with registered read data. Uses cpa_pkg for the entry type.
module cpa_stack_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  cpa_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output cpa_pkg::entry_t rdata
);

  cpa_pkg::entry_t mem [DEPTH];
  cpa_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/cidr_prefix_aggregator.sv =====
// CIDR prefix aggregator top level: control sequencer around the stack memory.
// Clear, rejected add, add to an empty stack, unknown kinds and reads out of
// range give their result strobe from a register loaded at the transfer; an
// in-range read first passes the READ state; any other add passes the CMP state,
// once more per merge that pops the top. One item at a time.
// Reset clears the entry count and the sequencer; memory contents are kept.
// The receiver cannot stall: every result is shown for exactly one cycle.
module cidr_prefix_aggregator #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cpa_pkg::in_item_t  in_data,
  output logic               out_valid,
  output cpa_pkg::out_item_t out_data
);

  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int CMPW = 17;

  cpa_pkg::fsm_t      state_r, state_nxt;
  logic [CW-1:0]      total_r, total_nxt;
  logic [31:0]        cur_net_r, cur_net_nxt;
  logic [5:0]         cur_len_r, cur_len_nxt;
  logic               merged_r, merged_nxt;
  logic               out_valid_r, out_valid_nxt;
  cpa_pkg::out_item_t out_data_r, out_data_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  cpa_pkg::entry_t    mem_wdata;
  logic [AW-1:0]      mem_raddr;
  cpa_pkg::entry_t    mem_rdata;

  logic               accept;
  logic               add_ok;
  logic               rd_ok;
  logic               covered;
  logic               mergeable;
  logic               merge_pop;
  logic               full;
  logic [31:0]        merge_mask;
  logic [5:0]         len_dec;

  cpa_stack_mem #(
    .DEPTH(STACK_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign busy   = (state_r != cpa_pkg::FSM_IDLE);
  assign accept = start && !busy;

  // Decode of the incoming item and of the top entry against the working prefix.
  always_comb begin
    add_ok = (in_data.prefix <= cpa_pkg::MAX_PREFIX) &&
             ((in_data.network & cpa_pkg::len_mask(in_data.prefix)) == in_data.network);
    rd_ok  = (CMPW'(in_data.index) < CMPW'(total_r)) &&
             (CMPW'(in_data.index) < CMPW'(STACK_DEPTH));
    len_dec    = cur_len_r - 6'd1;
    merge_mask = cpa_pkg::len_mask(len_dec);
    covered    = (cur_net_r & cpa_pkg::len_mask(mem_rdata.len)) == mem_rdata.net;
    mergeable  = (mem_rdata.len == cur_len_r) && (cur_len_r != 6'd0) &&
                 (((mem_rdata.net ^ cur_net_r) & merge_mask) == 32'd0);
    merge_pop  = !covered && mergeable && (total_r > CW'(1));
    full       = CMPW'(total_r) >= CMPW'(STACK_DEPTH);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpa_pkg::FSM_IDLE: begin
        if (accept) begin
          if (in_data.kind == cpa_pkg::KIND_READ && rd_ok) begin
            state_nxt = cpa_pkg::FSM_READ;
          end else if (in_data.kind == cpa_pkg::KIND_ADD && add_ok && total_r != '0) begin
            state_nxt = cpa_pkg::FSM_CMP;
          end
        end
      end
      cpa_pkg::FSM_READ: state_nxt = cpa_pkg::FSM_IDLE;
      cpa_pkg::FSM_CMP: begin
        if (!merge_pop) begin
          state_nxt = cpa_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = cpa_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    total_nxt     = total_r;
    cur_net_nxt   = cur_net_r;
    cur_len_nxt   = cur_len_r;
    merged_nxt    = merged_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(total_r);
    mem_wdata     = '{net: cur_net_r, len: cur_len_r};
    mem_raddr     = AW'(total_r - CW'(1));
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    case (state_r)
      cpa_pkg::FSM_IDLE: begin
        mem_raddr = (in_data.kind == cpa_pkg::KIND_READ) ? AW'(in_data.index)
                                                         : AW'(total_r - CW'(1));
        if (accept) begin
          cur_net_nxt = in_data.network;
          cur_len_nxt = in_data.prefix;
          merged_nxt  = 1'b0;
          case (in_data.kind)
            cpa_pkg::KIND_ADD: begin
              if (!add_ok) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = cpa_pkg::ST_UNALIGNED;
              end else if (total_r == '0) begin
                mem_we              = 1'b1;
                mem_waddr           = '0;
                mem_wdata           = '{net: in_data.network, len: in_data.prefix};
                total_nxt           = CW'(1);
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = cpa_pkg::ST_PUSHED;
              end
            end
            cpa_pkg::KIND_READ: begin
              if (!rd_ok) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = cpa_pkg::ST_RANGE;
              end
            end
            cpa_pkg::KIND_CLEAR: begin
              total_nxt           = '0;
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = cpa_pkg::ST_OK;
            end
            default: begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = cpa_pkg::ST_RANGE;
            end
          endcase
        end
      end
      cpa_pkg::FSM_READ: begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.status        = cpa_pkg::ST_OK;
        out_data_nxt.entry_network = mem_rdata.net;
        out_data_nxt.entry_prefix  = mem_rdata.len;
      end
      cpa_pkg::FSM_CMP: begin
        if (covered) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = merged_r ? cpa_pkg::ST_MERGED : cpa_pkg::ST_COVERED;
        end else if (mergeable) begin
          cur_net_nxt = cur_net_r & merge_mask;
          cur_len_nxt = len_dec;
          merged_nxt  = 1'b1;
          if (merge_pop) begin
            // Pop the top and fetch the entry below it for the next compare.
            total_nxt = total_r - CW'(1);
            mem_raddr = AW'(total_r - CW'(2));
          end else begin
            mem_we              = 1'b1;
            mem_waddr           = '0;
            mem_wdata           = '{net: cur_net_r & merge_mask, len: len_dec};
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = cpa_pkg::ST_MERGED;
          end
        end else if (full) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = cpa_pkg::ST_FULL;
        end else begin
          mem_we              = 1'b1;
          total_nxt           = total_r + CW'(1);
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = merged_r ? cpa_pkg::ST_MERGED : cpa_pkg::ST_PUSHED;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
    out_data_nxt.count = 11'(total_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpa_pkg::FSM_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_net_r  <= cur_net_nxt;
    cur_len_r  <= cur_len_nxt;
    merged_r   <= merged_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
